>>> rtl/bsee_pkg.sv
// shared types and constants for the block sad early exit core
`default_nettype none

package bsee_pkg;

  // field widths
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned SUM_W  = 22;
  localparam int unsigned BS_W   = 7;
  localparam int unsigned BPP_W  = 3;

  // saturation limit of the running sum
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // register reset values
  localparam logic [BS_W-1:0]  BS_RESET  = 7'd32;
  localparam logic [BPP_W-1:0] BPP_RESET = 3'd1;

  // register indexes, byte address bit 2
  localparam logic REG_BLOCK_SIZE = 1'b0;
  localparam logic REG_BPP        = 1'b1;

  // raw configuration as written
  typedef struct packed {
    logic [BS_W-1:0]  block_size;
    logic [BPP_W-1:0] bytes_per_pixel;
  } cfg_t;

  // one registered input item
  typedef struct packed {
    logic [PIX_W-1:0] pixel_a;
    logic [PIX_W-1:0] pixel_b;
    logic [SUM_W-1:0] threshold;
  } item_t;

endpackage

`default_nettype wire

>>> rtl/bsee_cfg.sv
// configuration registers behind the apb-style port
`default_nettype none

module bsee_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output bsee_pkg::cfg_t   cfg_o
);
  import bsee_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        REG_BLOCK_SIZE: cfg_d.block_size      = pwdata[BS_W-1:0];
        REG_BPP:        cfg_d.bytes_per_pixel = pwdata[BPP_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_size      <= BS_RESET;
      cfg_q.bytes_per_pixel <= BPP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      REG_BLOCK_SIZE: prdata = {{(32-BS_W){1'b0}}, cfg_q.block_size};
      REG_BPP:        prdata = {{(32-BPP_W){1'b0}}, cfg_q.bytes_per_pixel};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/bsee_in_reg.sv
// input register stage for incoming byte pairs
`default_nettype none

module bsee_in_reg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [bsee_pkg::PIX_W-1:0]  pixel_a_i,
  input  wire logic [bsee_pkg::PIX_W-1:0]  pixel_b_i,
  input  wire logic [bsee_pkg::SUM_W-1:0]  threshold_i,
  input  wire logic                        advance_i,
  output logic                             item_valid_o,
  output bsee_pkg::item_t                  item_o
);
  import bsee_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // hold while full and the next stage cannot take the item
  assign in_stall_o = valid_q & ~advance_i;

  always_comb begin
    valid_d = valid_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.pixel_a   <= pixel_a_i;
      item_q.pixel_b   <= pixel_b_i;
      item_q.threshold <= threshold_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

>>> rtl/bsee_accum.sv
// sad accumulator with row and block counters and result register
`default_nettype none

module bsee_accum #(
  parameter int unsigned MAX_BLOCK = 64,
  parameter int unsigned MAX_BPP   = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bsee_pkg::cfg_t              cfg_i,
  input  wire logic                        item_valid_i,
  input  wire bsee_pkg::item_t             item_i,
  output logic                             advance_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [bsee_pkg::SUM_W-1:0]       sad_sum_o,
  output logic                             early_exit_o
);
  import bsee_pkg::*;

  localparam int unsigned RW  = $clog2(MAX_BLOCK + 1);
  localparam int unsigned PW  = $clog2(MAX_BPP + 1);
  localparam int unsigned LW  = $clog2(MAX_BLOCK * MAX_BPP + 1);
  localparam int unsigned BW  = $clog2(MAX_BLOCK * MAX_BPP);
  localparam int unsigned RIW = $clog2(MAX_BLOCK);

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [BW-1:0]    byte_q, byte_d;
  logic [RIW-1:0]   row_q, row_d;
  logic             exited_q, exited_d;

  logic             out_valid_q, out_valid_d;
  logic [SUM_W-1:0] out_sum_q, res_sum;
  logic             out_ee_q, res_ee;
  logic             res_valid;

  logic [RW-1:0]    rows;
  logic [PW-1:0]    bpp;
  logic [LW-1:0]    row_len;
  logic [PIX_W-1:0] diff;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_add;
  logic             fire, row_end, last_row;

  // effective geometry with out-of-range values clamped
  always_comb begin
    if (cfg_i.block_size == '0) begin
      rows = RW'(1);
    end else if (32'(cfg_i.block_size) > MAX_BLOCK) begin
      rows = RW'(MAX_BLOCK);
    end else begin
      rows = RW'(cfg_i.block_size);
    end
    if (cfg_i.bytes_per_pixel == '0) begin
      bpp = PW'(1);
    end else if (32'(cfg_i.bytes_per_pixel) > MAX_BPP) begin
      bpp = PW'(MAX_BPP);
    end else begin
      bpp = PW'(cfg_i.bytes_per_pixel);
    end
  end

  assign row_len = LW'(rows * bpp);

  // pipeline moves when the result register is free or being taken
  assign advance_o = ~out_valid_q | ~out_stall_i;
  assign fire      = item_valid_i & advance_o;

  // absolute difference and saturating add
  assign diff     = (item_i.pixel_a > item_i.pixel_b) ? (item_i.pixel_a - item_i.pixel_b)
                                                      : (item_i.pixel_b - item_i.pixel_a);
  assign sum_wide = {1'b0, sum_q} + {{(SUM_W+1-PIX_W){1'b0}}, diff};
  always_comb begin
    if (exited_q) begin
      sum_add = sum_q;
    end else if (sum_wide[SUM_W]) begin
      sum_add = SUM_MAX;
    end else begin
      sum_add = sum_wide[SUM_W-1:0];
    end
  end

  assign row_end  = (32'(byte_q) + 32'd1) >= 32'(row_len);
  assign last_row = (32'(row_q) + 32'd1) >= 32'(rows);

  // counter, flag and result decisions for one item
  always_comb begin
    sum_d     = sum_q;
    byte_d    = byte_q;
    row_d     = row_q;
    exited_d  = exited_q;
    res_valid = 1'b0;
    res_sum   = sum_add;
    res_ee    = 1'b0;
    if (fire) begin
      if (!row_end) begin
        byte_d = byte_q + BW'(1);
        sum_d  = sum_add;
      end else if (last_row) begin
        res_valid = ~exited_q;
        sum_d     = '0;
        byte_d    = '0;
        row_d     = '0;
        exited_d  = 1'b0;
      end else begin
        byte_d = '0;
        row_d  = row_q + RIW'(1);
        sum_d  = sum_add;
        if (!exited_q && (sum_add > item_i.threshold)) begin
          exited_d  = 1'b1;
          res_valid = 1'b1;
          res_ee    = 1'b1;
        end
      end
    end
  end

  // output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      byte_q      <= '0;
      row_q       <= '0;
      exited_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      byte_q      <= byte_d;
      row_q       <= row_d;
      exited_q    <= exited_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_sum_q <= res_sum;
      out_ee_q  <= res_ee;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sad_sum_o    = out_sum_q;
  assign early_exit_o = out_ee_q;

endmodule

`default_nettype wire

>>> rtl/block_sad_early_exit_core.sv
// top level of the block sad early exit core
//
// byte pairs (pixel_a, pixel_b) of a reference and a candidate block enter
// in row order on the input channel together with the early exit threshold;
// the result channel carries sad_sum and early_exit. both channels use
// valid/stall and an item moves when valid is high and stall is low.
// block_size and bytes_per_pixel are set over the apb-style port at byte
// addresses 0 and 4; write them only while the core is idle.
// one item is taken every cycle while in_stall_o is low; the item that causes
// a result passes the input register and the sum update, and the result is
// held in the result register. at most one result per block: an early exit at
// a row end, or the total after the last row.
// reset clears the counters, the running sum and both valid flags and loads
// block_size 32 and bytes_per_pixel 1. while the receiver stalls the result
// holds; an empty input register takes one more item, then stall is raised.
`default_nettype none

module block_sad_early_exit_core #(
  parameter int unsigned MAX_BLOCK = 64,
  parameter int unsigned MAX_BPP   = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [bsee_pkg::PIX_W-1:0]  pixel_a_i,
  input  wire logic [bsee_pkg::PIX_W-1:0]  pixel_b_i,
  input  wire logic [bsee_pkg::SUM_W-1:0]  threshold_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [bsee_pkg::SUM_W-1:0]       sad_sum_o,
  output logic                             early_exit_o
);
  import bsee_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  advance;

  // configuration registers
  bsee_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  bsee_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_a_i    (pixel_a_i),
    .pixel_b_i    (pixel_b_i),
    .threshold_i  (threshold_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // accumulator and result register
  bsee_accum #(
    .MAX_BLOCK (MAX_BLOCK),
    .MAX_BPP   (MAX_BPP)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sad_sum_o    (sad_sum_o),
    .early_exit_o (early_exit_o)
  );

endmodule

`default_nettype wire

>>> verif/testbench.sv
// testbench for the block sad early exit core: sad predictor class, item drivers and checks
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bsee_pkg::*;

  localparam int unsigned BLOCK_CAP  = 64;
  localparam int unsigned BPP_CAP    = 4;
  localparam int unsigned PAIR_GOAL  = 1450;
  localparam int unsigned RESULT_MIN = 48;
  localparam int unsigned HOLD_LEN   = 200;
  localparam int unsigned DRAIN_GAP  = 6;
  localparam int unsigned BIG_PAIRS  = 300;
  localparam int unsigned CYCLE_CAP  = 3000000;

  // predicts sad results from accepted pairs and checks them in order
  class sad_tracker;
    typedef struct {
      logic [SUM_W-1:0] sum;
      logic             early;
    } sad_result_t;

    logic [BS_W-1:0]  block_size;
    logic [BPP_W-1:0] bytes_per_pixel;
    logic [SUM_W-1:0] run_sum;
    logic [7:0]       byte_pos;
    logic [5:0]       row_pos;
    bit               exited;
    sad_result_t      sad_expected[$];
    int unsigned      errors;
    int unsigned      counted_pairs;
    int unsigned      results_made;

    function new();
      block_size      = BS_RESET;
      bytes_per_pixel = BPP_RESET;
      clear_block();
    endfunction

    function void clear_block();
      run_sum  = '0;
      byte_pos = '0;
      row_pos  = '0;
      exited   = 1'b0;
    endfunction

    function int unsigned eff_rows();
      if (block_size == 0) return 1;
      if (block_size > BLOCK_CAP) return BLOCK_CAP;
      return 32'(block_size);
    endfunction

    function int unsigned eff_bpp();
      if (bytes_per_pixel == 0) return 1;
      if (bytes_per_pixel > BPP_CAP) return BPP_CAP;
      return 32'(bytes_per_pixel);
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == REG_BLOCK_SIZE) block_size = value[BS_W-1:0];
      else bytes_per_pixel = value[BPP_W-1:0];
    endfunction

    function void push_result(logic early);
      sad_result_t r;
      r.sum   = run_sum;
      r.early = early;
      sad_expected.push_back(r);
      results_made++;
    endfunction

    // one accepted pair: update the sums and counters, queue any result
    function void note_pair(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                            logic [SUM_W-1:0] thr);
      int unsigned rows, row_len, diff, total;
      rows    = eff_rows();
      row_len = rows * eff_bpp();
      counted_pairs++;
      if (!exited) begin
        diff  = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        total = int'(run_sum) + diff;
        run_sum = (total > int'(SUM_MAX)) ? SUM_MAX : total[SUM_W-1:0];
      end
      if (int'(byte_pos) + 1 < row_len) begin
        byte_pos = byte_pos + 8'd1;
        return;
      end
      byte_pos = '0;
      // last row: total without early exit, then a fresh block
      if (int'(row_pos) + 1 >= rows) begin
        if (!exited) push_result(1'b0);
        clear_block();
        return;
      end
      row_pos = row_pos + 6'd1;
      if (!exited && run_sum > thr) begin
        exited = 1'b1;
        push_result(1'b1);
      end
    endfunction

    function void check_result(logic [SUM_W-1:0] sum, logic early);
      sad_result_t want;
      if (sad_expected.size() == 0) begin
        $display("%0t: result with none expected, actual sad_sum %0d early_exit %0d",
                 $time, sum, early);
        errors++;
        return;
      end
      want = sad_expected.pop_front();
      if (sum !== want.sum) begin
        $display("%0t: sad_sum expected %0d actual %0d", $time, want.sum, sum);
        errors++;
      end
      if (early !== want.early) begin
        $display("%0t: early_exit expected %0d actual %0d", $time, want.early, early);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel, penable, pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [PIX_W-1:0] pixel_a_i, pixel_b_i;
  logic [SUM_W-1:0] threshold_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [SUM_W-1:0] sad_sum_o;
  logic             early_exit_o;

  sad_tracker  sad_sb = new();
  bit          calm;
  bit          no_gap;
  bit          hold_off;
  bit          hold_active;
  int unsigned cycle_count;

  block_sad_early_exit_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_a_i    (pixel_a_i),
    .pixel_b_i    (pixel_b_i),
    .threshold_i  (threshold_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sad_sum_o    (sad_sum_o),
    .early_exit_o (early_exit_o)
  );

  always #10 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sad_sb.check_result(sad_sum_o, early_exit_o);
      if (in_valid_i && !in_stall_o) sad_sb.note_pair(pixel_a_i, pixel_b_i, threshold_i);
    end
  end

  // receiver: stall bursts, free stretches and one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
        hold_active = 1'b1;
        repeat (HOLD_LEN) @(negedge clk_i);
        hold_active = 1'b0;
        hold_off    = 1'b0;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
    end
  end

  // offer one item, with an occasional idle burst in front; returns at a falling edge
  task automatic send_pair(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                           input logic [SUM_W-1:0] thr);
    calm = (sad_sb.counted_pairs + 150 >= PAIR_GOAL);
    if (!calm && !no_gap && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pixel_a_i   <= a;
    pixel_b_i   <= b;
    threshold_i <= thr;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // sender pause until every expected result is out and the pipe is empty
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sad_sb.sad_expected.size() != 0) @(negedge clk_i);
    repeat (DRAIN_GAP) @(negedge clk_i);
  endtask

  task automatic write_reg_apb(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sad_sb.write_reg(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input int unsigned bs, input int unsigned bpp);
    wait_drained();
    write_reg_apb(REG_BLOCK_SIZE, bs);
    write_reg_apb(REG_BPP, bpp);
  endtask

  // a run of pairs with one pixel pattern and a mostly fixed threshold
  task automatic run_block(input int unsigned count, input bit big);
    int unsigned      pix_mode, thr_mode, total, span;
    logic [PIX_W-1:0] a, b;
    logic [SUM_W-1:0] thr, t;
    total    = sad_sb.eff_rows() * sad_sb.eff_rows() * sad_sb.eff_bpp();
    pix_mode = big ? 0 : $urandom_range(0, 3);
    thr_mode = big ? 1 : $urandom_range(0, 3);
    span     = big ? 30000 : ((total * 100 > int'(SUM_MAX)) ? int'(SUM_MAX) : total * 100);
    case (thr_mode)
      0:       thr = '0;
      1:       thr = SUM_W'($urandom_range(0, span));
      2:       thr = SUM_W'($urandom);
      default: thr = SUM_MAX;
    endcase
    for (int unsigned i = 0; i < count; i++) begin
      case (pix_mode)
        0: begin
          a = PIX_W'($urandom);
          b = PIX_W'($urandom);
        end
        1: begin
          a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        2: begin
          a = PIX_W'($urandom);
          b = a ^ PIX_W'($urandom_range(0, 7));
        end
        default: begin
          a = PIX_W'($urandom);
          b = a;
        end
      endcase
      t = ($urandom_range(0, 9) == 0) ? SUM_W'($urandom) : thr;
      send_pair(a, b, t);
    end
  endtask

  initial begin
    int unsigned phase_no, bs, bpp, len, nblocks;
    bit          big;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    pixel_a_i   = '0;
    pixel_b_i   = '0;
    threshold_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset setting: first row exceeds a zero threshold, later rows ignored, block left open
    for (int i = 0; i < 32; i++) send_pair((i < 16) ? 8'hFF : 8'h00,
                                           (i < 16) ? 8'h00 : 8'hFF, '0);
    for (int i = 32; i < 96; i++) send_pair(PIX_W'($urandom), PIX_W'($urandom), '0);

    // zero registers act as one: the open block closes on the first pair, then every
    // pair is a whole block and the last row never exits
    set_config(0, 0);
    send_pair(8'h00, 8'hFF, '0);
    send_pair(8'hFF, 8'h00, SUM_MAX);
    send_pair(8'h00, 8'h00, '0);
    send_pair(8'hFF, 8'hFF, 22'h2AAAAA);

    // two by two: early exit then ignored pairs, then a full total
    set_config(2, 1);
    send_pair(8'hFF, 8'h00, '0);
    send_pair(8'h00, 8'hFF, '0);
    send_pair(8'h01, 8'h02, '0);
    send_pair(8'h03, 8'h04, '0);
    send_pair(8'h0A, 8'h14, SUM_MAX);
    send_pair(8'h14, 8'h0A, SUM_MAX);
    send_pair(8'h00, 8'hFF, SUM_MAX);
    send_pair(8'hFF, 8'h00, SUM_MAX);
    // leave a block open, shrink it to one row, finish it
    send_pair(8'h05, 8'h09, 22'h155555);
    wait_drained();
    write_reg_apb(REG_BLOCK_SIZE, 1);
    send_pair(8'h07, 8'h03, '0);

    // bytes per pixel above the cap acts as the cap
    set_config(1, 5);
    repeat (4) send_pair(8'hC8, 8'h64, 22'h000001);

    // sum equal to the threshold at a row end does not exit
    set_config(2, 1);
    send_pair(8'h0A, 8'h00, 22'd10);
    send_pair(8'h00, 8'h00, 22'd10);
    send_pair(8'h00, 8'h00, 22'd10);
    send_pair(8'h00, 8'h01, 22'd10);

    // random phases
    phase_no = 0;
    while (sad_sb.counted_pairs < PAIR_GOAL || sad_sb.results_made < RESULT_MIN) begin
      if (phase_no == 2) begin
        // long receiver hold-off while single pair blocks keep coming
        set_config(1, 1);
        no_gap   = 1'b1;
        hold_off = 1'b1;
        while (!hold_active) @(negedge clk_i);
        repeat (40) send_pair(PIX_W'($urandom), PIX_W'($urandom), SUM_W'($urandom));
        no_gap = 1'b0;
      end else begin
        // random geometry, or large blocks: a row and a bit, the rest left open for the next write
        big = (phase_no == 4 || phase_no == 6);
        if (phase_no == 4) begin
          bs  = 127;
          bpp = 7;
        end else if (phase_no == 6) begin
          bs  = BLOCK_CAP;
          bpp = BPP_CAP;
        end else if ($urandom_range(0, 19) < 16) begin
          bs  = $urandom_range(0, 6);
          bpp = $urandom_range(0, 7);
        end else begin
          bs  = $urandom_range(7, 16);
          bpp = $urandom_range(0, 2);
        end
        set_config(bs, bpp);
        len     = sad_sb.eff_rows() * sad_sb.eff_rows() * sad_sb.eff_bpp();
        nblocks = big ? 1 : 1 + 60 / len + $urandom_range(0, 2);
        repeat (nblocks) run_block(big ? BIG_PAIRS : len, big);
        // sometimes leave a block open across the next register write
        if (!big && len > 1 && $urandom_range(0, 4) == 0)
          run_block($urandom_range(1, len - 1), 1'b0);
      end
      phase_no++;
    end

    // drain and let the pipe settle
    wait_drained();
    repeat (20) @(negedge clk_i);
    if (sad_sb.sad_expected.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, sad_sb.sad_expected.size());
    if (sad_sb.errors == 0 && sad_sb.sad_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/bsee_pkg.sv
rtl/bsee_cfg.sv
rtl/bsee_in_reg.sv
rtl/bsee_accum.sv
rtl/block_sad_early_exit_core.sv
verif/testbench.sv
